// ===== rtl/vucr_pkg.sv =====
// Package for the video unit CPU register block: widths, register codes, commands.
// No dependencies.
`default_nettype none
package vucr_pkg;
    localparam int SPRITE_BYTES_D    = 256;
    localparam int NAMETABLE_BYTES_D = 2048;
    localparam int PATTERN_BYTES_D   = 8192;
    localparam int DOTS_PER_LINE_D   = 341;
    localparam int LINES_PER_FRAME_D = 262;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [13:0] PAL_BASE = 14'h3F00;
    localparam logic [13:0] NT_BASE  = 14'h2000;
    localparam logic [8:0]  VBL_LINE = 9'd241;
endpackage
`default_nettype wire

// ===== rtl/video_unit_cpu_registers.sv =====
// Top level of the video unit CPU register block: registers, counters, memories.
// Depends on vucr_pkg.
`default_nettype none
// Usage:
//   One input channel (in_valid/in_ready) carries command, reg_index and
//   write_data; one output channel (out_valid/out_ready) returns one result per
//   item: read_data, reg_ok, nmi_line, vblank, frame_done.
//   An item passes an issue stage, which starts the memory read and updates
//   register state, and a merge stage, which merges read data and updates the
//   read buffer, before the output register. A new item is taken every cycle
//   while in_ready is high (throughput one per cycle).
//   Back-to-back data reads are covered: the address register updates in the
//   issue cycle, so the next item already sees the stepped address.
//   Reset (rst_n low, asynchronous) clears state and valid flags, status to 101.
//   Memories are not cleared. When out_ready is low the result waits in the
//   output register and a skid register holds one more in-flight item; input
//   is stalled while the skid register is full, or while the output is stalled
//   with an item in the merge stage.
//   mirror_we/mirror_wd write the mirroring mode (0 vertical, 1 horizontal).
module video_unit_cpu_registers
    import vucr_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_D,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_D
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mirror_we,
    input  wire logic       mirror_wd,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [2:0] reg_index,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic            reg_ok,
    output logic            nmi_line,
    output logic            vblank,
    output logic            frame_done
);
    localparam int NTW = $clog2(NAMETABLE_BYTES);

    typedef struct packed {
        logic [7:0] rd;
        logic       ok;
        logic       nmi;
        logic       vbl;
        logic       done;
    } res_t;

    logic [7:0] spr_mem [SPRITE_BYTES_D];
    logic [7:0] nt_mem  [NAMETABLE_BYTES];
    logic [7:0] pal_mem [32];
    logic [7:0] pat_mem [PATTERN_BYTES_D];

    logic        mirror_reg;
    logic [7:0]  ctrl_reg, mask_reg, spaddr_reg, rbuf_reg, rbuf_next;
    logic [2:0]  status_reg, status_next;
    logic        toggle_reg, toggle_next, nmi_reg, nmi_next, odd_reg, odd_next;
    logic [14:0] t_reg, t_next, v_reg, v_next;
    logic [2:0]  fx_reg, fx_next;
    logic [8:0]  dot_reg, dot_next, line_reg, line_next;
    logic [7:0]  ctrl_next, mask_next, spaddr_next;

    // stage 2: pending data read result
    logic        s2_valid_reg, s2_dread_reg, s2_pal_reg, s2_spr_reg;
    logic [1:0]  s2_sel_reg;
    logic [7:0]  s2_old_reg;
    res_t        s2_res_reg;

    logic [7:0]  pat_q, nt_q, pal_q, spr_q, mem_q;
    logic [7:0]  rbuf_eff;
    res_t        out_reg, skid_reg, s2_res;
    logic        out_v_reg, skid_v_reg;

    logic        acc, rd_c, wr_c, done_c, ok_c, rend;
    logic [13:0] a14;
    logic [NTW-1:0] nt_idx;
    logic [4:0]  pal_idx;
    logic [7:0]  rd_c_val;
    logic [14:0] inc;

    assign in_ready = !skid_v_reg && !(s2_valid_reg && out_v_reg && !out_ready);
    assign acc  = in_valid && in_ready;
    assign rd_c = acc && command == CMD_READ;
    assign wr_c = acc && command == CMD_WRITE;
    assign a14  = v_reg[13:0];
    assign inc  = ctrl_reg[2] ? 15'd32 : 15'd1;
    assign rend = mask_reg[3] || mask_reg[4];

    always_comb
    begin
        logic [13:0] n;
        n = a14 & 14'h2FFF;
        if (mirror_reg)
            nt_idx = NTW'({n[11], n[9:0]});
        else
            nt_idx = NTW'(n[10:0]);
        pal_idx = a14[4:0] & ((a14[1:0] == 2'b00) ? 5'h0F : 5'h1F);
    end

    // memories: write on issue, registered read
    always_ff @(posedge clk)
    begin
        if (wr_c && reg_index == REG_SPDATA) spr_mem[spaddr_reg] <= write_data;
        if (wr_c && reg_index == REG_DATA)
        begin
            if (a14 < NT_BASE) pat_mem[a14[12:0]] <= write_data;
            else if (a14 < PAL_BASE) nt_mem[nt_idx] <= write_data;
            else pal_mem[pal_idx] <= write_data;
        end
        pat_q <= pat_mem[a14[12:0]];
        nt_q  <= nt_mem[nt_idx];
        pal_q <= pal_mem[pal_idx];
        spr_q <= spr_mem[spaddr_reg];
    end

    always_comb
    begin
        ctrl_next = ctrl_reg; mask_next = mask_reg; spaddr_next = spaddr_reg;
        status_next = status_reg; toggle_next = toggle_reg; nmi_next = nmi_reg;
        odd_next = odd_reg; t_next = t_reg; v_next = v_reg; fx_next = fx_reg;
        dot_next = dot_reg; line_next = line_reg;
        done_c = 1'b0; ok_c = 1'b0; rd_c_val = 8'd0;
        if (acc && command == CMD_TICK)
        begin
            if (line_reg == 9'd0 && dot_reg == 9'd1)
            begin
                status_next = 3'd0; nmi_next = 1'b0;
            end
            else if (line_reg == VBL_LINE && dot_reg == 9'd1)
            begin
                status_next = status_reg | 3'b100;
                if (ctrl_reg[7]) nmi_next = 1'b1;
            end
            dot_next = dot_reg + ((line_reg == 9'd0 && dot_reg == 9'd339 && odd_reg && rend)
                ? 9'd2 : 9'd1);
            if (dot_next > 9'(DOTS_PER_LINE_D - 1))
            begin
                dot_next = 9'd0;
                line_next = line_reg + 9'd1;
                if (line_next > 9'(LINES_PER_FRAME - 1))
                begin
                    line_next = 9'd0; odd_next = !odd_reg; done_c = 1'b1;
                end
            end
        end
        else if (rd_c)
        begin
            case (reg_index)
                REG_STATUS:
                begin
                    ok_c = 1'b1;
                    // buffer may still be updating from a data read in stage 2
                    rd_c_val = {status_reg, rbuf_eff[4:0]};
                    status_next = status_reg & 3'b011; nmi_next = 1'b0; toggle_next = 1'b0;
                end
                REG_SPDATA: ok_c = 1'b1;
                REG_DATA:
                begin
                    ok_c = 1'b1;
                    v_next = v_reg + inc;
                end
                default: ok_c = 1'b0;
            endcase
        end
        else if (wr_c)
        begin
            ok_c = 1'b1;
            case (reg_index)
                REG_CTRL:
                begin
                    ctrl_next = write_data;
                    t_next[11:10] = write_data[1:0];
                    if (!write_data[7]) nmi_next = 1'b0;
                    else if (status_reg[2]) nmi_next = 1'b1;
                end
                REG_MASK:   mask_next = write_data;
                REG_SPADDR: spaddr_next = write_data;
                REG_SPDATA: spaddr_next = spaddr_reg + 8'd1;
                REG_SCROLL:
                begin
                    if (!toggle_reg)
                    begin
                        fx_next = write_data[2:0];
                        t_next[4:0] = write_data[7:3];
                    end
                    else
                    begin
                        t_next[14:12] = write_data[2:0];
                        t_next[9:5] = write_data[7:3];
                    end
                    toggle_next = !toggle_reg;
                end
                REG_ADDR:
                begin
                    if (!toggle_reg)
                        t_next = {1'b0, write_data[5:0], t_reg[7:0]};
                    else
                    begin
                        t_next = {t_reg[14:8], write_data};
                        v_next = t_next;
                    end
                    toggle_next = !toggle_reg;
                end
                REG_DATA: v_next = v_reg + inc;
                default:  ok_c = 1'b0;
            endcase
        end
    end

    // stage 2 merge of read data
    always_comb
    begin
        case (s2_sel_reg)
            2'd0:    mem_q = pat_q;
            2'd1:    mem_q = nt_q;
            default: mem_q = pal_q;
        endcase
        s2_res = s2_res_reg;
        rbuf_next = rbuf_reg;
        if (s2_spr_reg) s2_res.rd = spr_q;
        if (s2_dread_reg)
        begin
            rbuf_next = mem_q;
            s2_res.rd = s2_pal_reg ? mem_q : s2_old_reg;
        end
    end

    // buffer for a data read issued right behind one still in stage 2
    assign rbuf_eff = (s2_valid_reg && s2_dread_reg) ? rbuf_next : rbuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0; ctrl_reg <= '0; mask_reg <= '0; spaddr_reg <= '0;
            status_reg <= 3'b101; toggle_reg <= 1'b0; nmi_reg <= 1'b0; odd_reg <= 1'b0;
            t_reg <= '0; v_reg <= '0; fx_reg <= '0; dot_reg <= '0; line_reg <= '0;
            rbuf_reg <= '0; s2_valid_reg <= 1'b0; out_v_reg <= 1'b0; skid_v_reg <= 1'b0;
        end
        else
        begin
            if (mirror_we) mirror_reg <= mirror_wd;
            ctrl_reg <= ctrl_next; mask_reg <= mask_next; spaddr_reg <= spaddr_next;
            status_reg <= status_next; toggle_reg <= toggle_next; nmi_reg <= nmi_next;
            odd_reg <= odd_next; t_reg <= t_next; v_reg <= v_next; fx_reg <= fx_next;
            dot_reg <= dot_next; line_reg <= line_next;
            if (s2_valid_reg) rbuf_reg <= rbuf_next;
            s2_valid_reg <= acc;
            // output register with skid
            if (out_v_reg && !out_ready)
            begin
                if (s2_valid_reg) skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= skid_v_reg || s2_valid_reg;
                skid_v_reg <= skid_v_reg && s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dread_reg <= rd_c && reg_index == REG_DATA;
        s2_spr_reg   <= rd_c && reg_index == REG_SPDATA;
        s2_pal_reg   <= a14 >= PAL_BASE;
        s2_sel_reg   <= (a14 < NT_BASE) ? 2'd0 : (a14 < PAL_BASE) ? 2'd1 : 2'd2;
        s2_old_reg   <= rbuf_eff;
        s2_res_reg   <= '{rd: rd_c_val, ok: ok_c, nmi: nmi_next,
                          vbl: status_next[2], done: done_c};
        if (out_v_reg && !out_ready)
        begin
            if (s2_valid_reg) skid_reg <= s2_res;
        end
        else
        begin
            out_reg  <= skid_v_reg ? skid_reg : s2_res;
            skid_reg <= s2_res;
        end
    end

    assign out_valid  = out_v_reg;
    assign read_data  = out_reg.rd;
    assign reg_ok     = out_reg.ok;
    assign nmi_line   = out_reg.nmi;
    assign vblank     = out_reg.vbl;
    assign frame_done = out_reg.done;

    // fine X is held for the rendering side, which is not part of this block
    logic fx_unused;
    assign fx_unused = ^fx_reg;
endmodule
`default_nettype wire
